// ===== sv/sdi_pkg.sv =====
`timescale 1ns / 1ps

package sdi_pkg;

    localparam int MAX_ENTRIES  = 4096;
    localparam int MAX_KEY_LEN  = 64;
    localparam int STRING_BYTES = 65536;

    localparam int ENT_AW = 12;   // entry / bucket / overflow index
    localparam int CNT_W  = 13;   // counts up to MAX_ENTRIES
    localparam int KEY_AW = 6;    // key buffer address
    localparam int LEN_W  = 7;    // key length 0..64
    localparam int OFF_W  = 17;   // string offset 0..65536
    localparam int STR_AW = 16;   // string store address
    localparam int FLT_AW = 13;   // filter word address
    localparam int FLT_W  = 64;
    localparam int LOW_W  = 20;   // stored low hash bits

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [LOW_W-1:0]  lcrc;
        logic              dup;
        logic [ENT_AW-1:0] value;
        logic              has_next;
        logic [ENT_AW-1:0] nxt;
    } ent_t;

    typedef struct packed {
        logic [31:0]      crc_next;
        logic [LEN_W-1:0] len_next;
        logic             long_next;
    } key_stat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== sv/string_dictionary_intern.sv =====
`timescale 1ns / 1ps

// string interning dictionary, chained hash table keyed by crc-32c
// input channel: one key byte per beat (in_valid / in_stall), key_last marks the
//   final beat, key_empty marks a beat with no byte, func is sampled on the last beat
// output channel: one result beat per last input beat (out_valid / out_stall)
// bytes are taken one per cycle while idle; crc is updated as they arrive
// after the last beat a sequencer walks the bucket and its overflow chain entry by
// entry, and a hash-matching entry of the same length gets a full string compare, byte
// by byte, through one shared byte comparator
// an add writes the new entry, links it to the chain tail when the bucket is taken, and
//   then copies the key bytes into the string store
// a too-long key skips the search and goes straight to the result register
// the first beat of the next key can be taken the cycle after the result beat
// in_stall is high from the last beat until the result beat is taken
// the result sits in an output register; while out_stall is high it holds and no
//   new beat is taken
// after reset a clearing pass empties the filter and bucket table; in_stall stays high
//   meanwhile

module string_dictionary_intern
    import sdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic        key_empty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] entry_index,
    output logic        found,
    output logic        added,
    output logic [1:0]  status
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FILT = 4'd2;
    localparam logic [3:0] S_ENT  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_INFO = 4'd5;
    localparam logic [3:0] S_CRD  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_MISS = 4'd8;
    localparam logic [3:0] S_LINK = 4'd9;
    localparam logic [3:0] S_CPR  = 4'd10;
    localparam logic [3:0] S_CPW  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam int INFO_W = OFF_W + LEN_W;
    localparam int BKT_W  = $bits(ent_t) + 1;

    // control
    logic [3:0]        state_reg, state_next;
    logic [FLT_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  ecount_reg, ecount_next;
    logic [CNT_W-1:0]  ocount_reg, ocount_next;
    logic [OFF_W-1:0]  off_reg, off_next;

    // per key working registers
    logic [31:0]       hash_reg, hash_next;
    logic [LEN_W-1:0]  klen_reg, klen_next;
    logic              add_reg, add_next;
    logic              fhit_reg, fhit_next;
    logic              bvalid_reg, bvalid_next;
    logic              full_reg, full_next;
    logic              mark_reg, mark_next;
    logic              dseen_reg, dseen_next;
    logic [FLT_W-1:0]  fword_reg, fword_next;
    ent_t              ent_reg, ent_next;
    logic              curb_reg, curb_next;
    logic [ENT_AW-1:0] cura_reg, cura_next;
    logic [OFF_W-1:0]  start_reg, start_next;
    logic [KEY_AW-1:0] cidx_reg, cidx_next;

    // result
    logic [11:0]       idx_reg, idx_next;
    logic              found_reg, found_next;
    logic              added_reg, added_next;
    logic [1:0]        stat_reg, stat_next;

    // memory ports
    logic              bkt_we;
    logic [ENT_AW-1:0] bkt_waddr, bkt_raddr;
    logic [BKT_W-1:0]  bkt_wdata, bkt_rdata;
    logic              ovf_we;
    logic [ENT_AW-1:0] ovf_waddr;
    ent_t              ovf_wdata, ovf_rdata;
    logic              info_we;
    logic [INFO_W-1:0] info_wdata, info_rdata;
    logic              str_we;
    logic [STR_AW-1:0] str_waddr, str_raddr;
    logic [7:0]        str_rdata;
    logic              flt_we;
    logic [FLT_AW-1:0] flt_waddr, flt_raddr;
    logic [FLT_W-1:0]  flt_wdata, flt_rdata;
    logic [7:0]        key_rdata;

    key_stat_t         kstat;
    logic              take;
    logic [31:0]       hash_in;
    logic [ENT_AW-1:0] bucket;
    logic [ENT_AW-1:0] newidx;
    logic              lmatch;
    logic              last_byte;
    ent_t              fresh;
    ent_t              bent;

    assign take      = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign hash_in   = ~kstat.crc_next;
    assign bucket    = hash_reg[31:32-ENT_AW];
    assign newidx    = ecount_reg[ENT_AW-1:0];
    assign lmatch    = ent_reg.lcrc == hash_reg[LOW_W-1:0];
    assign last_byte = {1'b0, cidx_reg} == klen_reg - 1'b1;
    assign bent      = ent_t'(bkt_rdata[BKT_W-2:0]);

    assign entry_index = idx_reg;
    assign found       = found_reg;
    assign added       = added_reg;
    assign status      = stat_reg;

    sdi_key_unit u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .key_byte  (key_byte),
        .key_last  (key_last),
        .key_empty (key_empty),
        .raddr     (cidx_reg),
        .rdata     (key_rdata),
        .stat      (kstat)
    );

    // bucket table: {valid, entry}
    sdi_ram #(.W(BKT_W), .A(ENT_AW)) u_bkt (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    sdi_ram #(.W($bits(ent_t)), .A(ENT_AW)) u_ovf (
        .clk   (clk),
        .we    (ovf_we),
        .waddr (ovf_waddr),
        .wdata (ovf_wdata),
        .raddr (ent_reg.nxt),
        .rdata (ovf_rdata)
    );

    // per entry string info: {start offset, length}
    sdi_ram #(.W(INFO_W), .A(ENT_AW)) u_info (
        .clk   (clk),
        .we    (info_we),
        .waddr (newidx),
        .wdata (info_wdata),
        .raddr (ent_reg.value),
        .rdata (info_rdata)
    );

    sdi_ram #(.W(8), .A(STR_AW)) u_str (
        .clk   (clk),
        .we    (str_we),
        .waddr (str_waddr),
        .wdata (key_rdata),
        .raddr (str_raddr),
        .rdata (str_rdata)
    );

    sdi_ram #(.W(FLT_W), .A(FLT_AW)) u_flt (
        .clk   (clk),
        .we    (flt_we),
        .waddr (flt_waddr),
        .wdata (flt_wdata),
        .raddr (flt_raddr),
        .rdata (flt_rdata)
    );

    // read addresses: hash from the incoming crc while idle, latched hash after
    assign bkt_raddr  = (state_reg == S_IDLE) ? hash_in[31:32-ENT_AW] : bucket;
    assign flt_raddr  = (state_reg == S_IDLE) ? hash_in[FLT_AW+5:6] : hash_reg[FLT_AW+5:6];
    assign str_raddr  = STR_AW'(start_reg + OFF_W'(cidx_reg));
    assign str_waddr  = STR_AW'(off_reg + OFF_W'(cidx_reg));
    assign info_wdata = {off_reg, klen_reg};

    always_comb
    begin
        fresh.lcrc     = hash_reg[LOW_W-1:0];
        fresh.dup      = dseen_reg;
        fresh.value    = newidx;
        fresh.has_next = 1'b0;
        fresh.nxt      = '0;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ecount_next = ecount_reg;
        ocount_next = ocount_reg;
        off_next    = off_reg;
        hash_next   = hash_reg;
        klen_next   = klen_reg;
        add_next    = add_reg;
        fhit_next   = fhit_reg;
        bvalid_next = bvalid_reg;
        full_next   = full_reg;
        mark_next   = mark_reg;
        dseen_next  = dseen_reg;
        fword_next  = fword_reg;
        ent_next    = ent_reg;
        curb_next   = curb_reg;
        cura_next   = cura_reg;
        start_next  = start_reg;
        cidx_next   = cidx_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        added_next  = added_reg;
        stat_next   = stat_reg;
        bkt_we      = 1'b0;
        bkt_waddr   = bucket;
        bkt_wdata   = {1'b1, ent_reg};
        ovf_we      = 1'b0;
        ovf_waddr   = cura_reg;
        ovf_wdata   = ent_reg;
        info_we     = 1'b0;
        str_we      = 1'b0;
        flt_we      = 1'b0;
        flt_waddr   = hash_reg[FLT_AW+5:6];
        flt_wdata   = fword_reg | (FLT_W'(1) << hash_reg[5:0]);

        case (state_reg)
            S_CLR:
            begin
                // sweep filter words and buckets to zero
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg[ENT_AW-1:0];
                bkt_wdata = '0;
                flt_we    = 1'b1;
                flt_waddr = clr_reg;
                flt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take && key_last)
                begin
                    hash_next = hash_in;
                    klen_next = kstat.len_next;
                    add_next  = !func;
                    if (kstat.long_next)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        added_next = 1'b0;
                        stat_next  = ST_LONG;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FILT;
                    end
                end
            end
            S_FILT:
            begin
                fhit_next   = flt_rdata[hash_reg[5:0]];
                fword_next  = flt_rdata;
                bvalid_next = bkt_rdata[BKT_W-1];
                ent_next    = bent;
                curb_next   = 1'b1;
                dseen_next  = 1'b0;
                full_next   = ecount_reg >= CNT_W'(MAX_ENTRIES)
                    || ({1'b0, off_reg} + (OFF_W+1)'(klen_reg)) > (OFF_W+1)'(STRING_BYTES)
                    || (bkt_rdata[BKT_W-1] && ocount_reg >= CNT_W'(MAX_ENTRIES));
                mark_next   = 1'b0;
                if (add_reg)
                begin
                    mark_next = !(ecount_reg >= CNT_W'(MAX_ENTRIES)
                        || ({1'b0, off_reg} + (OFF_W+1)'(klen_reg)) > (OFF_W+1)'(STRING_BYTES)
                        || (bkt_rdata[BKT_W-1] && ocount_reg >= CNT_W'(MAX_ENTRIES)));
                end
                state_next = bkt_rdata[BKT_W-1] ? S_ENT : S_MISS;
            end
            S_ENT:
            begin
                if (lmatch && mark_reg)
                begin
                    // on an add with room, entries sharing the low hash become duplicates
                    ent_next.dup = 1'b1;
                    dseen_next   = 1'b1;
                    if (curb_reg)
                    begin
                        bkt_we    = 1'b1;
                        bkt_wdata = {1'b1, ent_next};
                    end
                    else
                    begin
                        ovf_we    = 1'b1;
                        ovf_wdata = ent_next;
                    end
                end
                if (lmatch && fhit_reg)
                begin
                    state_next = S_INFO;
                end
                else
                begin
                    state_next = ent_reg.has_next ? S_RD : S_MISS;
                end
            end
            S_RD:
            begin
                ent_next   = ovf_rdata;
                curb_next  = 1'b0;
                cura_next  = ent_reg.nxt;
                state_next = S_ENT;
            end
            S_INFO:
            begin
                if (info_rdata[LEN_W-1:0] != klen_reg)
                begin
                    state_next = ent_reg.has_next ? S_RD : S_MISS;
                end
                else if (klen_reg == '0)
                begin
                    idx_next   = ent_reg.value;
                    found_next = 1'b1;
                    added_next = 1'b0;
                    stat_next  = ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    start_next = info_rdata[INFO_W-1:LEN_W];
                    cidx_next  = '0;
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (str_rdata != key_rdata)
                begin
                    state_next = ent_reg.has_next ? S_RD : S_MISS;
                end
                else if (last_byte)
                begin
                    idx_next   = ent_reg.value;
                    found_next = 1'b1;
                    added_next = 1'b0;
                    stat_next  = ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    cidx_next  = cidx_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_MISS:
            begin
                if (!add_reg || full_reg)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    added_next = 1'b0;
                    stat_next  = (add_reg && full_reg) ? ST_FULL : ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    info_we = 1'b1;
                    flt_we  = 1'b1;
                    if (!bvalid_reg)
                    begin
                        bkt_we    = 1'b1;
                        bkt_wdata = {1'b1, fresh};
                    end
                    else
                    begin
                        ovf_we    = 1'b1;
                        ovf_waddr = ocount_reg[ENT_AW-1:0];
                        ovf_wdata = fresh;
                    end
                    cidx_next = '0;
                    if (bvalid_reg)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        state_next = (klen_reg == '0) ? S_DONE : S_CPR;
                    end
                end
            end
            S_LINK:
            begin
                // chain the tail to the new overflow entry
                ent_next.has_next = 1'b1;
                ent_next.nxt      = ocount_reg[ENT_AW-1:0];
                if (curb_reg)
                begin
                    bkt_we    = 1'b1;
                    bkt_wdata = {1'b1, ent_next};
                end
                else
                begin
                    ovf_we    = 1'b1;
                    ovf_wdata = ent_next;
                end
                state_next = (klen_reg == '0) ? S_DONE : S_CPR;
            end
            S_CPR:
            begin
                state_next = S_CPW;
            end
            S_CPW:
            begin
                str_we = 1'b1;
                if (last_byte)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cidx_next  = cidx_reg + 1'b1;
                    state_next = S_CPR;
                end
            end
            S_DONE:
            begin
                ecount_next = ecount_reg + 1'b1;
                if (bvalid_reg)
                begin
                    ocount_next = ocount_reg + 1'b1;
                end
                off_next   = off_reg + OFF_W'(klen_reg);
                idx_next   = newidx;
                found_next = 1'b0;
                added_next = 1'b1;
                stat_next  = ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            ecount_reg <= '0;
            ocount_reg <= '0;
            off_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ecount_reg <= ecount_next;
            ocount_reg <= ocount_next;
            off_reg    <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        klen_reg   <= klen_next;
        add_reg    <= add_next;
        fhit_reg   <= fhit_next;
        bvalid_reg <= bvalid_next;
        full_reg   <= full_next;
        mark_reg   <= mark_next;
        dseen_reg  <= dseen_next;
        fword_reg  <= fword_next;
        ent_reg    <= ent_next;
        curb_reg   <= curb_next;
        cura_reg   <= cura_next;
        start_reg  <= start_next;
        cidx_reg   <= cidx_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        added_reg  <= added_next;
        stat_reg   <= stat_next;
    end

    // busy once the last beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && key_last |=> in_stall)
        else $error("input taken after last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && added |-> !found && status == ST_OK)
        else $error("added result with found or bad status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !found && !added && entry_index == '0)
        else $error("error result carries an index");

    assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg <= ecount_reg && ecount_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry counts out of range");

endmodule

// ===== sv/sdi_ram.sv =====
`timescale 1ns / 1ps

module sdi_ram #(
    parameter int W = 8,
    parameter int A = 8
) (
    input  logic         clk,
    input  logic         we,
    input  logic [A-1:0] waddr,
    input  logic [W-1:0] wdata,
    input  logic [A-1:0] raddr,
    output logic [W-1:0] rdata
);

    localparam int D = 1 << A;

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sdi_key_unit.sv =====
`timescale 1ns / 1ps

module sdi_key_unit
    import sdi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        key_byte,
    input  logic              key_last,
    input  logic              key_empty,
    input  logic [KEY_AW-1:0] raddr,
    output logic [7:0]        rdata,
    output key_stat_t         stat
);

    logic [7:0]       key_mem [MAX_KEY_LEN];
    logic [LEN_W-1:0] len_reg;
    logic [31:0]      crc_reg;
    logic             long_reg;
    logic             room;

    assign room = len_reg < LEN_W'(MAX_KEY_LEN);

    always_comb
    begin
        stat.crc_next  = key_empty ? crc_reg : crc_byte(crc_reg, key_byte);
        stat.len_next  = (!key_empty && room) ? len_reg + 1'b1 : len_reg;
        stat.long_next = long_reg || (!key_empty && !room);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            crc_reg  <= CRC_INIT;
            long_reg <= 1'b0;
        end
        else if (take)
        begin
            if (key_last)
            begin
                len_reg  <= '0;
                crc_reg  <= CRC_INIT;
                long_reg <= 1'b0;
            end
            else
            begin
                len_reg  <= stat.len_next;
                crc_reg  <= stat.crc_next;
                long_reg <= stat.long_next;
            end
        end
    end

    // key byte store, registered read
    always_ff @(posedge clk)
    begin
        if (take && !key_empty && room)
        begin
            key_mem[len_reg[KEY_AW-1:0]] <= key_byte;
        end
        rdata <= key_mem[raddr];
    end

endmodule

// ===== sim/string_dictionary_intern_tb.sv =====
`timescale 1ns / 1ps

module string_dictionary_intern_tb;
    import sdi_pkg::*;

    // a key beat as the driver presents it
    typedef struct {
        logic       fn;
        logic [7:0] kb;
        logic       kl;
        logic       ke;
    } key_beat_t;

    // a result beat as the block returns it
    typedef struct {
        logic [11:0] idx;
        logic        fnd;
        logic        add;
        logic [1:0]  st;
    } lookup_res_t;

    // one dictionary entry: low hash bits plus its place in the chain
    typedef struct {
        logic [LOW_W-1:0]  lcrc;
        logic [ENT_AW-1:0] value;
        logic              has_next;
        logic [ENT_AW-1:0] nxt;
    } chain_ent_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  key_byte;
    logic        key_last;
    logic        key_empty;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] entry_index;
    logic        found;
    logic        added;
    logic [1:0]  status;

    string_dictionary_intern u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key_byte    (key_byte),
        .key_last    (key_last),
        .key_empty   (key_empty),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_index (entry_index),
        .found       (found),
        .added       (added),
        .status      (status)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------
    // dictionary shadow: bucket heads, overflow chain, strings, filter
    // ---------------------------------------------------------------
    bit          bkt_valid [4096];
    chain_ent_t  bkt_ent [4096];
    chain_ent_t  ovf_ent [4096];
    int unsigned str_off [4097];
    logic [7:0]  str_mem [65536];
    bit          flt_bit [524288];
    int unsigned n_entries;
    int unsigned n_ovf;

    // key being collected
    logic [7:0]  cur_key [64];
    int unsigned cur_len;
    bit          cur_long;
    logic [31:0] cur_crc;

    lookup_res_t expected_results [$];
    key_beat_t   pending_beats [$];
    bit          pause_req;
    int          fail_count;
    int unsigned hold_cnt;

    // stored keys reused by the generator to hit found paths
    logic [7:0]  known_keys [$][$];

    function automatic logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 32'h82F63B78;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic bit key_matches(int unsigned v);
        int unsigned s;
        int unsigned e;
        if (v >= n_entries)
            return 0;
        s = str_off[v];
        e = str_off[v + 1];
        if (e - s != cur_len)
            return 0;
        for (int i = 0; i < cur_len; i++)
        begin
            if (str_mem[s + i] != cur_key[i])
                return 0;
        end
        return 1;
    endfunction

    // walk the bucket chain; returns 1 and the index when the key is stored
    function automatic bit chain_lookup(logic [31:0] h, output int unsigned idx);
        int unsigned b;
        chain_ent_t  e;
        b = h[31:20];
        idx = 0;
        if (!flt_bit[h[18:0]] || !bkt_valid[b])
            return 0;
        e = bkt_ent[b];
        forever
        begin
            if (e.lcrc == h[19:0] && key_matches(e.value))
            begin
                idx = e.value;
                return 1;
            end
            if (!e.has_next)
                return 0;
            e = ovf_ent[e.nxt];
        end
    endfunction

    // append the key; returns status
    function automatic logic [1:0] chain_insert(logic [31:0] h, output int unsigned idx);
        int unsigned b;
        int unsigned s;
        chain_ent_t  fresh;
        b = h[31:20];
        idx = 0;
        if (n_entries >= MAX_ENTRIES)
            return ST_FULL;
        s = str_off[n_entries];
        if (cur_len > STRING_BYTES - s)
            return ST_FULL;
        if (bkt_valid[b] && n_ovf >= MAX_ENTRIES)
            return ST_FULL;
        str_off[n_entries + 1] = s + cur_len;
        for (int i = 0; i < cur_len; i++)
            str_mem[s + i] = cur_key[i];
        fresh.lcrc = h[19:0];
        fresh.value = n_entries;
        fresh.has_next = 0;
        fresh.nxt = 0;
        if (!bkt_valid[b])
        begin
            bkt_valid[b] = 1;
            bkt_ent[b] = fresh;
        end
        else
        begin
            // find the tail and link; dup marks are not visible at the ports
            if (!bkt_ent[b].has_next)
            begin
                bkt_ent[b].has_next = 1;
                bkt_ent[b].nxt = n_ovf;
            end
            else
            begin
                int unsigned t;
                t = bkt_ent[b].nxt;
                while (ovf_ent[t].has_next)
                    t = ovf_ent[t].nxt;
                ovf_ent[t].has_next = 1;
                ovf_ent[t].nxt = n_ovf;
            end
            ovf_ent[n_ovf] = fresh;
            n_ovf++;
        end
        idx = n_entries;
        n_entries++;
        flt_bit[h[18:0]] = 1;
        return ST_OK;
    endfunction

    // predictor: one accepted beat in, at most one expected result out
    function automatic void intern_beat(key_beat_t bt);
        lookup_res_t r;
        logic [31:0] h;
        int unsigned idx;
        if (!bt.ke)
        begin
            if (cur_len < MAX_KEY_LEN)
            begin
                cur_key[cur_len] = bt.kb;
                cur_len++;
            end
            else
                cur_long = 1;
            cur_crc = crc32c_step(cur_crc, bt.kb);
        end
        if (!bt.kl)
            return;
        h = ~cur_crc;
        r = '{idx: 12'd0, fnd: 1'b0, add: 1'b0, st: ST_OK};
        if (cur_long)
            r.st = ST_LONG;
        else if (chain_lookup(h, idx))
        begin
            r.idx = idx[11:0];
            r.fnd = 1'b1;
        end
        else if (bt.fn == 1'b0)
        begin
            r.st = chain_insert(h, idx);
            if (r.st == ST_OK)
            begin
                r.add = 1'b1;
                r.idx = idx[11:0];
            end
        end
        expected_results.push_back(r);
        cur_len = 0;
        cur_long = 0;
        cur_crc = 32'hffffffff;
    endfunction

    // random gap: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // queue a whole key; bytes may be interleaved with empty beats
    task automatic push_key(logic [7:0] k[$], logic fn, bit sprinkle);
        key_beat_t bt;
        for (int i = 0; i < k.size(); i++)
        begin
            if (sprinkle && $urandom_range(9) == 0)
            begin
                bt = '{fn: 1'($urandom_range(1)), kb: 8'($urandom_range(255)),
                       kl: 1'b0, ke: 1'b1};
                pending_beats.push_back(bt);
            end
            bt = '{fn: fn, kb: k[i], kl: (i == k.size() - 1), ke: 1'b0};
            pending_beats.push_back(bt);
        end
        if (k.size() == 0)
        begin
            bt = '{fn: fn, kb: 8'($urandom_range(255)), kl: 1'b1, ke: 1'b1};
            pending_beats.push_back(bt);
        end
    endtask

    function automatic void rand_key(int unsigned len, output logic [7:0] k[$]);
        k = {};
        for (int i = 0; i < len; i++)
            k.push_back(8'($urandom_range(255)));
    endfunction

    // stall as seen at the last rising edge
    logic in_stall_q;

    // ---------------------------------------------------------------
    // driver: changes inputs on the falling edge, holds a stalled beat
    // ---------------------------------------------------------------
    int unsigned drv_gap;
    key_beat_t   drv_beat;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // retire the beat accepted at the last rising edge
            if (in_valid && !in_stall_q)
            begin
                void'(pending_beats.pop_front());
                drv_gap = gap_len();
            end
            if (in_valid && in_stall_q)
            begin
                // stalled: hold payload
            end
            else if (drv_gap > 0)
            begin
                drv_gap--;
                in_valid <= 1'b0;
            end
            else if (pause_req && expected_results.size() != 0)
                in_valid <= 1'b0;
            else if (pending_beats.size() != 0)
            begin
                drv_beat = pending_beats[0];
                in_valid <= 1'b1;
                func <= drv_beat.fn;
                key_byte <= drv_beat.kb;
                key_last <= drv_beat.kl;
                key_empty <= drv_beat.ke;
            end
            else
                in_valid <= 1'b0;
            // receiver stall
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
            begin
                hold_cnt = gap_len();
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ---------------------------------------------------------------
    int unsigned idle_cycles;
    lookup_res_t got;
    lookup_res_t want;

    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                intern_beat(pending_beats[0]);
            end
            if (out_valid && !out_stall)
            begin
                got = '{idx: entry_index, fnd: found, add: added, st: status};
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.idx !== want.idx)
                    begin
                        $error("entry_index expected %0d got %0d", want.idx, got.idx);
                        fail_count++;
                    end
                    if (got.fnd !== want.fnd)
                    begin
                        $error("found expected %0d got %0d", want.fnd, got.fnd);
                        fail_count++;
                    end
                    if (got.add !== want.add)
                    begin
                        $error("added expected %0d got %0d", want.add, got.add);
                        fail_count++;
                    end
                    if (got.st !== want.st)
                    begin
                        $error("status expected %0d got %0d", want.st, got.st);
                        fail_count++;
                    end
                end
            end
            // the idle timeout leaves room for the clearing pass after reset
            if (idle_cycles > 40000)
            begin
                $display("string_dictionary_intern regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial
    begin
        logic [7:0] k[$];
        int unsigned n_items;
        int unsigned pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        key_byte = 8'd0;
        key_last = 1'b0;
        key_empty = 1'b0;
        out_stall = 1'b0;
        drv_gap = 0;
        hold_cnt = 0;
        pause_req = 0;
        fail_count = 0;
        idle_cycles = 0;
        n_entries = 0;
        n_ovf = 0;
        cur_len = 0;
        cur_long = 0;
        cur_crc = 32'hffffffff;
        str_off[0] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty key get, add, add again, then keys 00 and ff added and ff got
        k = {};
        push_key(k, 1'b1, 0);
        push_key(k, 1'b0, 0);
        push_key(k, 1'b0, 0);
        k = {8'h00};
        push_key(k, 1'b0, 0);
        k = {8'hff};
        push_key(k, 1'b0, 0);
        push_key(k, 1'b1, 0);
        // empty beats sprinkled in, a lone empty non-last beat
        pending_beats.push_back('{fn: 1'b1, kb: 8'hff, kl: 1'b0, ke: 1'b1});
        k = {8'h55, 8'haa, 8'h01};
        push_key(k, 1'b1, 1);
        push_key(k, 1'b0, 1);
        push_key(k, 1'b1, 1);
        // longest key, then one byte too long, add and get
        rand_key(MAX_KEY_LEN, k);
        push_key(k, 1'b0, 0);
        push_key(k, 1'b1, 0);
        rand_key(MAX_KEY_LEN + 1, k);
        push_key(k, 1'b0, 0);
        push_key(k, 1'b1, 0);
        k = {8'h61};
        push_key(k, 1'b0, 0);

        wait (pending_beats.size() == 0);
        // sender holds off until every result is back
        pause_req = 1;
        wait (expected_results.size() == 0);
        pause_req = 0;

        // random: mostly short keys, repeats of stored ones, some long ones
        n_items = 0;
        while (n_items < 1350)
        begin
            pick = $urandom_range(99);
            if (pick < 35 && known_keys.size() != 0)
                k = known_keys[$urandom_range(known_keys.size() - 1)];
            else if (pick < 40)
                rand_key($urandom_range(MAX_KEY_LEN + 4, MAX_KEY_LEN - 2), k);
            else if (pick < 45)
                rand_key(0, k);
            else
                rand_key($urandom_range(6, 1), k);
            if (k.size() <= MAX_KEY_LEN && known_keys.size() < 200)
                known_keys.push_back(k);
            n_items += (k.size() == 0) ? 1 : k.size();
            push_key(k, 1'($urandom_range(1)), 1);
            wait (pending_beats.size() < 16);
        end

        wait (pending_beats.size() == 0);
        wait (expected_results.size() == 0);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("string_dictionary_intern regression: pass");
        else
            $display("string_dictionary_intern regression: fail");
        $finish;
    end

endmodule
